>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// check prop on every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that expr never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

>>> rtl/rctd_pkg.sv
// ----------------------------------------------------------------------------
// rctd_pkg
// Word types, operation codes and table constants for the row clock table.
// ----------------------------------------------------------------------------
package rctd_pkg;

	localparam int unsigned DEF_TABLE_ROWS = 1024;

	localparam int unsigned ROW_W   = 10;
	localparam int unsigned CLK_W   = 31;
	localparam int unsigned COUNT_W = 11;
	localparam int unsigned ENTRY_W = CLK_W + 1;

	// an entry of all ones is an empty row; a stored clock always has its top bit clear
	localparam logic [ENTRY_W-1:0] ENTRY_INVALID = '1;
	localparam logic [COUNT_W-1:0] NEW_MAX       = '1;

	localparam logic [1:0] OP_INSERT      = 2'd0;
	localparam logic [1:0] OP_START_DRAIN = 2'd1;
	localparam logic [1:0] OP_NEXT_DRAIN  = 2'd2;
	localparam logic [1:0] OP_READ_CLEAR  = 2'd3;

	typedef struct packed {
		logic [1:0]       operation;
		logic [ROW_W-1:0] row_number;
		logic [CLK_W-1:0] clock_value;
		logic [CLK_W-1:0] clock_limit;
	} cmd_t;

	typedef struct packed {
		logic               row_found;
		logic [ROW_W-1:0]   found_row;
		logic [COUNT_W-1:0] valid_rows;
		logic [COUNT_W-1:0] new_rows;
	} res_t;

endpackage

>>> rtl/row_clock_table_drain_core.sv
// ----------------------------------------------------------------------------
// row_clock_table_drain_core
// Per-row clock table in one synchronous memory, with insert and in-order drain.
// ----------------------------------------------------------------------------
// After reset the block sweeps the table to empty, one row per cycle, and
// cmd_stall stays high during the sweep. Then it takes one command word at a
// time. An insert reads its row, then writes it; read-and-clear and an insert
// beyond the table read nothing. A drain reads one table row per cycle from
// the scan position until it finds a row whose clock is within the limit or
// the scan reaches the table end; a drain on an empty table or an exhausted
// scan reads no row. The single memory read port sets this rate. A result
// waiting in the output register does not block the next command from being
// taken; it only holds the following result.
module row_clock_table_drain_core #(
	parameter int unsigned TABLE_ROWS = rctd_pkg::DEF_TABLE_ROWS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  rctd_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output rctd_pkg::res_t res
);
	import rctd_pkg::*;

	localparam int unsigned IDX_W = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_ROWS + 1);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_CHECK = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   clr_q;
	logic [1:0]         op_q;
	logic [IDX_W-1:0]   row_q;
	logic [CLK_W-1:0]   cval_q;
	logic [CLK_W-1:0]   limit_q;
	logic [CNT_W-1:0]   scan_q;
	logic [CNT_W-1:0]   vcnt_q;
	logic [COUNT_W-1:0] ncnt_q;
	logic               found_q;
	logic [ENTRY_W-1:0] rd_q;
	logic               res_valid_q;
	res_t               res_q;

	logic [ENTRY_W-1:0] mem [TABLE_ROWS];

	logic               accept;
	logic               in_range;
	logic               hit;
	logic               drain_op;
	logic [CNT_W-1:0]   scan_nxt;
	logic               scan_end;
	logic               out_free;
	logic               mem_re;
	logic [IDX_W-1:0]   mem_ra;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_wa;
	logic [ENTRY_W-1:0] mem_wd;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign in_range  = {7'd0, cmd.row_number} < 17'(TABLE_ROWS);
	assign hit       = !rd_q[ENTRY_W-1] && (rd_q[CLK_W-1:0] <= limit_q);
	assign drain_op  = (op_q == OP_START_DRAIN) || (op_q == OP_NEXT_DRAIN);
	assign scan_nxt  = scan_q + CNT_W'(1);
	assign scan_end  = (scan_nxt == CNT_W'(TABLE_ROWS));
	assign out_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// memory port control
	always_comb begin
		mem_re = 1'b0;
		mem_ra = '0;
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = ENTRY_INVALID;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd.operation)
						OP_INSERT: begin
							mem_re = in_range;
							mem_ra = IDX_W'(cmd.row_number);
						end
						OP_START_DRAIN: begin
							mem_re = (vcnt_q != '0);
						end
						OP_NEXT_DRAIN: begin
							mem_re = (vcnt_q != '0) && (scan_q != CNT_W'(TABLE_ROWS));
							mem_ra = scan_q[IDX_W-1:0];
						end
						default: begin
							mem_re = 1'b0;
						end
					endcase
				end
			end
			ST_CHECK: begin
				if (!drain_op) begin
					mem_we = 1'b1;
					mem_wa = row_q;
					mem_wd = {1'b0, cval_q};
				end else if (hit) begin
					mem_we = 1'b1;
					mem_wa = scan_q[IDX_W-1:0];
				end else begin
					// look at the following row next cycle
					mem_re = !scan_end;
					mem_ra = scan_nxt[IDX_W-1:0];
				end
			end
			ST_EMIT: begin
				mem_re = 1'b0;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			row_q  <= IDX_W'(cmd.row_number);
			cval_q <= cmd.clock_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			op_q        <= OP_INSERT;
			limit_q     <= '0;
			scan_q      <= '0;
			vcnt_q      <= '0;
			ncnt_q      <= '0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// the emit state loads its own word
			if (res_valid_q && !res_stall && state_q != ST_EMIT) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(TABLE_ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						op_q    <= cmd.operation;
						found_q <= 1'b0;
						if (cmd.operation == OP_START_DRAIN) begin
							scan_q  <= '0;
							limit_q <= cmd.clock_limit;
						end
						state_q <= mem_re ? ST_CHECK : ST_EMIT;
					end
				end
				ST_CHECK: begin
					if (!drain_op) begin
						if (rd_q[ENTRY_W-1]) begin
							vcnt_q <= vcnt_q + CNT_W'(1);
							if (ncnt_q != NEW_MAX) begin
								ncnt_q <= ncnt_q + COUNT_W'(1);
							end
						end
						state_q <= ST_EMIT;
					end else if (hit) begin
						// stay on the found row; it is now empty and gets skipped
						vcnt_q  <= vcnt_q - CNT_W'(1);
						found_q <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						scan_q <= scan_nxt;
						if (scan_end) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						res_valid_q       <= 1'b1;
						res_q.row_found   <= found_q;
						res_q.found_row   <= found_q ? ROW_W'(scan_q) : '0;
						res_q.valid_rows  <= COUNT_W'(vcnt_q);
						res_q.new_rows    <= ncnt_q;
						if (op_q == OP_READ_CLEAR) begin
							ncnt_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

`include "assert_macros.svh"

	`ASSERT_AT(a_vcnt_bound, clk, arst_n, vcnt_q <= CNT_W'(TABLE_ROWS), "valid count above table size")
	`ASSERT_AT(a_scan_bound, clk, arst_n, scan_q <= CNT_W'(TABLE_ROWS), "scan position past table end")
	`ASSERT_AT(a_hit_dec, clk, arst_n, (state_q == ST_CHECK && drain_op && hit) |=> (vcnt_q == $past(vcnt_q) - CNT_W'(1)), "drained row not taken off the valid count")
	`ASSERT_NEVER(a_clear_blocks, clk, arst_n, state_q == ST_CLEAR && !cmd_stall, "command taken during clearing sweep")

endmodule

>>> tb/sv/row_clock_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// row_clock_checker
// Watches both channels of the row clock table, keeps its own copy of the
// table, scan position and counts, and compares every result word field by
// field with the oldest predicted one.
// ----------------------------------------------------------------------------
module row_clock_checker #(
	parameter int unsigned TABLE_ROWS = rctd_pkg::DEF_TABLE_ROWS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  logic           cmd_stall,
	input  rctd_pkg::cmd_t cmd,
	input  logic           res_valid,
	input  logic           res_stall,
	input  rctd_pkg::res_t res,
	output int unsigned    error_count,
	output int unsigned    words_due
);

	import rctd_pkg::*;

	localparam int unsigned PRINT_CAP = 40;
	localparam int unsigned IDX_W     = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;

	logic             row_live  [TABLE_ROWS];
	logic [CLK_W-1:0] row_clock [TABLE_ROWS];
	logic [CLK_W-1:0] limit_latched;
	int unsigned      scan_at;
	int unsigned      live_rows;
	int unsigned      fresh_rows;
	int unsigned      result_index;
	res_t             due_results[$];

	initial begin
		row_live      = '{default: 1'b0};
		row_clock     = '{default: '0};
		limit_latched = '0;
		scan_at       = 0;
		live_rows     = 0;
		fresh_rows    = 0;
		result_index  = 0;
		error_count   = 0;
		words_due     = 0;
	end

	// Update the table copy for one command word and return its result word.
	function automatic res_t apply_command(cmd_t w);
		res_t r;
		logic hit;
		r   = '0;
		hit = 1'b0;
		case (w.operation)
			OP_INSERT: begin
				if (32'(w.row_number) < TABLE_ROWS) begin
					if (!row_live[w.row_number]) begin
						row_live[w.row_number] = 1'b1;
						live_rows++;
						if (fresh_rows < 32'(NEW_MAX))
							fresh_rows++;
					end
					row_clock[w.row_number] = w.clock_value;
				end
				r.new_rows = COUNT_W'(fresh_rows);
			end
			OP_START_DRAIN, OP_NEXT_DRAIN: begin
				if (w.operation == OP_START_DRAIN) begin
					scan_at       = 0;
					limit_latched = w.clock_limit;
				end
				// an empty table leaves the scan where it is
				if (live_rows != 0) begin
					while (!hit && scan_at < TABLE_ROWS) begin
						if (row_live[IDX_W'(scan_at)] &&
								row_clock[IDX_W'(scan_at)] <= limit_latched) begin
							hit = 1'b1;
							row_live[IDX_W'(scan_at)] = 1'b0;
							live_rows--;
						end else begin
							scan_at++;
						end
					end
				end
				r.row_found = hit;
				if (hit)
					r.found_row = ROW_W'(scan_at);
				r.new_rows = COUNT_W'(fresh_rows);
			end
			OP_READ_CLEAR: begin
				r.new_rows = COUNT_W'(fresh_rows);
				fresh_rows = 0;
			end
		endcase
		r.valid_rows = COUNT_W'(live_rows);
		return r;
	endfunction

	task automatic check_field(string fname, int unsigned want, int unsigned got);
		if (want != got) begin
			error_count++;
			if (error_count <= PRINT_CAP)
				$display("%0t ns: result word %0d %s expected %0d, actual %0d",
					$time, result_index, fname, want, got);
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				due_results.push_back(apply_command(cmd));
			if (res_valid && !res_stall) begin
				if (due_results.size() == 0) begin
					error_count++;
					if (error_count <= PRINT_CAP)
						$display("%0t ns: result word %0d arrived with none expected, actual %p",
							$time, result_index, res);
				end else begin
					want = due_results.pop_front();
					check_field("row_found",  32'(want.row_found),  32'(res.row_found));
					check_field("found_row",  32'(want.found_row),  32'(res.found_row));
					check_field("valid_rows", 32'(want.valid_rows), 32'(res.valid_rows));
					check_field("new_rows",   32'(want.new_rows),   32'(res.new_rows));
				end
				result_index++;
			end
			words_due = due_results.size();
		end
	end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives command words into the row clock table: a directed opening over the
// drain corner cases and random words under four flow-control mixes.
// Checking lives in row_clock_checker; this module only makes stimulus and
// gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

	import rctd_pkg::*;

	localparam int unsigned TABLE_ROWS     = DEF_TABLE_ROWS;
	localparam int unsigned RANDOM_ITEMS   = 1928;
	localparam longint      CYCLE_LIMIT    =
		longint'(RANDOM_ITEMS + 64) * (TABLE_ROWS + 3) * 4
		+ 4 * TABLE_ROWS;
	localparam logic [CLK_W-1:0] CLK_MAX = '1;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	cmd_t        cmd       = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_t        res;
	int unsigned error_count;
	int unsigned words_due;

	int unsigned send_gap_pct   = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned sent_words     = 0;
	longint      cycle_count    = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	row_clock_table_drain_core #(
		.TABLE_ROWS(TABLE_ROWS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	row_clock_checker #(
		.TABLE_ROWS(TABLE_ROWS)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.error_count(error_count),
		.words_due  (words_due)
	);

	always @(posedge clk) begin
		res_stall <= (recv_stall_pct != 0) && ($urandom_range(1, 100) <= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d result words outstanding",
				cycle_count, words_due);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic cmd_t word_of(logic [1:0] op, logic [ROW_W-1:0] row,
			logic [CLK_W-1:0] cval, logic [CLK_W-1:0] lim);
		cmd_t w;
		w.operation   = op;
		w.row_number  = row;
		w.clock_value = cval;
		w.clock_limit = lim;
		return w;
	endfunction

	// Bias rows toward both ends of the table and clocks toward small values
	// so that overwrites, hits and misses against the limit all happen often.
	function automatic cmd_t random_word();
		cmd_t        w;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			w.operation = OP_INSERT;
		else if (pick < 55)
			w.operation = OP_START_DRAIN;
		else if (pick < 90)
			w.operation = OP_NEXT_DRAIN;
		else
			w.operation = OP_READ_CLEAR;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			w.row_number = ROW_W'($urandom_range(0, 15));
		else if (pick == 4)
			w.row_number = ROW_W'($urandom_range(2**ROW_W - 16, 2**ROW_W - 1));
		else
			w.row_number = ROW_W'($urandom());
		if ($urandom_range(0, 1))
			w.clock_value = CLK_W'($urandom_range(0, 63));
		else
			w.clock_value = CLK_W'($urandom());
		pick = $urandom_range(0, 9);
		if (pick < 4)
			w.clock_limit = CLK_W'($urandom_range(0, 63));
		else if (pick < 6)
			w.clock_limit = CLK_MAX;
		else if (pick == 6)
			w.clock_limit = '0;
		else
			w.clock_limit = CLK_W'($urandom());
		return w;
	endfunction

	// Hold the word until the block takes it; idle first at the sender's rate.
	task automatic push_word(cmd_t w);
		while (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd       <= w;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		sent_words++;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// drains on an empty table
		push_word(word_of(OP_NEXT_DRAIN, '0, '0, '0));
		push_word(word_of(OP_START_DRAIN, 10'h155, 31'h2AAAAAAA, CLK_MAX));
		// field extremes, then an overwrite of a live row
		push_word(word_of(OP_INSERT, '0, '0, '0));
		push_word(word_of(OP_INSERT, '1, CLK_MAX, CLK_MAX));
		push_word(word_of(OP_INSERT, 10'h155, 31'h55555555, 31'h2AAAAAAA));
		push_word(word_of(OP_INSERT, 10'h2AA, 31'h2AAAAAAA, 31'h55555555));
		push_word(word_of(OP_INSERT, '0, 31'd5, '0));
		push_word(word_of(OP_READ_CLEAR, '1, CLK_MAX, CLK_MAX));
		push_word(word_of(OP_READ_CLEAR, '0, '0, '0));
		// nothing under the limit: scan runs out and stays out
		push_word(word_of(OP_START_DRAIN, '0, '0, 31'd4));
		push_word(word_of(OP_NEXT_DRAIN, '0, '0, '0));
		push_word(word_of(OP_INSERT, 10'd1, 31'd4, '0));
		push_word(word_of(OP_NEXT_DRAIN, '0, '0, CLK_MAX));
		// clock equal to the limit, then skip the row just drained
		push_word(word_of(OP_START_DRAIN, '0, '0, 31'd5));
		push_word(word_of(OP_NEXT_DRAIN, '0, '0, '0));
		push_word(word_of(OP_NEXT_DRAIN, '0, '0, '0));
		push_word(word_of(OP_START_DRAIN, '0, '0, 31'h2AAAAAAA));
		push_word(word_of(OP_START_DRAIN, '0, '0, CLK_MAX));
		push_word(word_of(OP_NEXT_DRAIN, '0, '0, '0));
		push_word(word_of(OP_NEXT_DRAIN, '0, '0, '0));
		push_word(word_of(OP_INSERT, '1, '0, '0));
		push_word(word_of(OP_START_DRAIN, '0, CLK_MAX, '0));
		push_word(word_of(OP_READ_CLEAR, '0, '0, '0));

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_gap_pct = 0;  recv_stall_pct <= 0;  end
				1: begin send_gap_pct = 51; recv_stall_pct <= 0;  end
				2: begin send_gap_pct = 0;  recv_stall_pct <= 51; end
				default: begin send_gap_pct = 11; recv_stall_pct <= 11; end
			endcase
			repeat (RANDOM_ITEMS / 4)
				push_word(random_word());
		end

		send_gap_pct = 0;
		recv_stall_pct <= 0;
		push_word(word_of(OP_READ_CLEAR, '0, '0, '0));
		cmd_valid <= 1'b0;

		@(negedge clk);
		while (words_due != 0)
			@(negedge clk);
		repeat (32) @(negedge clk);

		$display("Sent %0d command words in %0d cycles: directed drain corners, then random",
			sent_words, cycle_count);
		$display("words under four idle and stall mixes");
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
